[rtl/repb_pkg.sv]
// Package for the rotated e-paper alpha pixel blender.
// Types, operation and register codes, and gray/quantize helpers. No dependencies.
package repb_pkg;
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_BLEND = 2'd2;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_TURNS = 3'd1;
    localparam logic [2:0] REG_W     = 3'd2;
    localparam logic [2:0] REG_H     = 3'd3;
    localparam logic [2:0] REG_FG    = 3'd4;
    localparam logic [2:0] REG_BG    = 3'd5;
    localparam logic [2:0] REG_BGEN  = 3'd6;

    localparam int CFG_W = 24;

    typedef struct packed {
        logic [1:0] mode;   // 0,1,2 (3 folded to 2)
        logic [7:0] fg_gray;
        logic [7:0] bg_gray;
        logic       bg_en;
    } t_blend_cfg;

    function automatic logic [7:0] gray_of(input logic [23:0] rgb);
        logic [17:0] s;
        s = 18'(rgb[23:16]) * 18'd77 + 18'(rgb[15:8]) * 18'd150
          + 18'(rgb[7:0]) * 18'd29 + 18'd128;
        return s[15:8];
    endfunction

    // Division by 255 of values below 65535: q = (v + 1 + (v >> 8)) >> 8
    function automatic logic [7:0] div255(input logic [16:0] v);
        logic [17:0] t;
        t = 18'(v) + 18'd1 + 18'(v[16:8]);
        return t[15:8];
    endfunction

    function automatic logic [3:0] quantize(input logic [7:0] g, input logic [1:0] mode);
        logic [8:0] c;
        logic [9:0] m;
        c = (9'(g) + 9'd8) >> 4;
        m = 10'(g) * 10'd3 + 10'd127;
        case (mode)
            2'd0:    return {3'd0, g[7]};
            2'd1:    return (m >= 10'd765) ? 4'd3 : (m >= 10'd510) ? 4'd2 :
                            (m >= 10'd255) ? 4'd1 : 4'd0;
            default: return (c > 9'd15) ? 4'd15 : c[3:0];
        endcase
    endfunction

    function automatic logic [7:0] expand(input logic [3:0] c, input logic [1:0] mode);
        case (mode)
            2'd0:    return c[0] ? 8'd255 : 8'd0;
            2'd1:    return 8'(c[1:0]) * 8'd85;
            default: return 8'(c) * 8'd17;
        endcase
    endfunction
endpackage

[rtl/repb_addr.sv]
// Address stage: bounds check and rotated byte/bit placement of a blend pixel.
// Depends on repb_pkg.
module repb_addr import repb_pkg::*; (
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_turns,
    input  logic [10:0] i_width,
    input  logic [10:0] i_height,
    input  logic [15:0] i_x,
    input  logic [15:0] i_y,
    output logic        o_visible,
    output logic [22:0] o_index,
    output logic [2:0]  o_bitpos
);
    logic [10:0] nw, pitch, xu, yu, col, row, sub, lane, rx, ry;
    logic [1:0]  sh;
    logic [21:0] prod;
    always_comb begin
        xu = i_x[10:0];
        yu = i_y[10:0];
        o_visible = !i_x[15] && !i_y[15] && (i_x[14:0] < 15'(i_width))
                    && (i_y[14:0] < 15'(i_height));
        nw = (i_turns[0] == 1'b0) ? i_width : i_height;
        sh = (i_mode == 2'd0) ? 2'd3 : (i_mode == 2'd1) ? 2'd2 : 2'd1;
        pitch = (i_mode == 2'd0) ? 11'((12'(nw) + 12'd7) >> 3) : (nw >> sh);
        lane = (11'd1 << sh) - 11'd1;
        rx = i_width - 11'd1 - xu;
        ry = i_height - 11'd1 - yu;
        case (i_turns)
            2'd0:    begin col = xu; row = yu; sub = lane - (xu & lane); end
            2'd1:    begin col = yu; row = rx; sub = lane - (yu & lane); end
            2'd2:    begin col = rx; row = ry; sub = xu & lane; end
            default: begin col = ry; row = xu; sub = yu & lane; end
        endcase
        prod = row * pitch;
        o_index = 23'(prod) + 23'(col >> sh);
        o_bitpos = 3'(sub << i_mode);
    end
endmodule

[rtl/repb_mix.sv]
// Blend datapath: base gray select, alpha mix, divide by 255, quantize.
// Depends on repb_pkg.
module repb_mix import repb_pkg::*; (
    input  t_blend_cfg i_cfg,
    input  logic [7:0] i_byte,
    input  logic [2:0] i_bitpos,
    input  logic [7:0] i_alpha,
    output logic [7:0] o_byte,
    output logic [3:0] o_color
);
    logic [7:0]  fmask, stored, base, mixed;
    logic [3:0]  fld;
    logic [16:0] sum;
    always_comb begin
        fmask = ((8'd1 << (4'd1 << i_cfg.mode)) - 8'd1) << i_bitpos;
        stored = (i_byte & fmask) >> i_bitpos;
        fld = stored[3:0];
        base = i_cfg.bg_en ? i_cfg.bg_gray : expand(fld, i_cfg.mode);
        sum = 17'(base) * 17'(8'd255 - i_alpha) + 17'(i_cfg.fg_gray) * 17'(i_alpha) + 17'd127;
        mixed = div255(sum);
        o_color = quantize(mixed, i_cfg.mode);
        o_byte = (i_byte & ~fmask) | ((8'(o_color) << i_bitpos) & fmask);
    end
endmodule

[rtl/rotated_epaper_alpha_pixel_blender_top.sv]
// Top level of the rotated e-paper alpha pixel blender.
// Holds config, the frame memory and the read-modify-write sequencer; uses repb_addr, repb_mix.
// A blend that writes and an in-range read pass S_IDLE (accept, compute the address), S_READ
// (read the frame memory, registered port) and S_MIX (mix, write back, register the result).
// Loads, skipped blends and out-of-range items finish in S_IDLE. With one memory port, input is
// held off until S_IDLE. No clearing pass; the store is undefined until loaded. A result waits in
// an output register; input is held off while it waits unless it is taken in the same cycle.
module rotated_epaper_alpha_pixel_blender_top import repb_pkg::*; #(
    parameter int FRAME_BYTES = 524288
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] operation, [20:2] byte_address, [28:21] byte_value, [44:29] pos_x,
    // [60:45] pos_y, [68:61] alpha, [71:69] zero
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [8] pixel_written, [12:9] new_color, [13] out_of_range, [15:14] zero
    output logic [15:0] m_axis_tdata
);
    localparam int AW = $clog2(FRAME_BYTES);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_MIX} t_state;

    logic [1:0]  r_mode, r_turns;
    logic [10:0] r_w, r_h;
    logic [23:0] r_fg, r_bg;
    logic        r_bgen;
    logic [7:0]  r_mem [FRAME_BYTES];
    logic [7:0]  r_rdata;
    t_state      r_state;
    logic [1:0]  r_op;
    logic [AW-1:0] r_addr;
    logic [7:0]  r_alpha;
    logic [2:0]  r_bitpos;
    logic        r_ovalid;
    logic [15:0] r_odata;
    logic        n_ovalid;

    logic [1:0]  in_op;
    logic [18:0] in_addr;
    logic        vis, acc, fire, rd_ok, in_oor;
    logic [22:0] bidx;
    logic [2:0]  bpos;
    logic [1:0]  mode_eff;
    t_blend_cfg  cfg;
    logic [7:0]  new_byte;
    logic [3:0]  color;

    assign in_op = s_axis_tdata[1:0];
    assign in_addr = s_axis_tdata[20:2];
    assign mode_eff = (r_mode == 2'd3) ? 2'd2 : r_mode;
    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign cfg = '{mode: mode_eff, fg_gray: gray_of(r_fg), bg_gray: gray_of(r_bg),
                   bg_en: r_bgen};

    repb_addr u_addr (
        .i_mode(mode_eff), .i_turns(r_turns), .i_width(r_w), .i_height(r_h),
        .i_x(s_axis_tdata[44:29]), .i_y(s_axis_tdata[60:45]),
        .o_visible(vis), .o_index(bidx), .o_bitpos(bpos));

    repb_mix u_mix (
        .i_cfg(cfg), .i_byte(r_rdata), .i_bitpos(r_bitpos), .i_alpha(r_alpha),
        .o_byte(new_byte), .o_color(color));

    assign fire = acc && (in_op == OP_BLEND) && vis && (s_axis_tdata[68:61] != 8'd0)
                  && (bidx < 23'(FRAME_BYTES));
    assign rd_ok = (in_op == OP_READ) && (23'(in_addr) < 23'(FRAME_BYTES));
    assign in_oor = ((in_op == OP_LOAD || in_op == OP_READ)
                     && 23'(in_addr) >= 23'(FRAME_BYTES))
                    || (in_op == OP_BLEND && vis && s_axis_tdata[68:61] != 8'd0);

    always_comb begin
        n_ovalid = r_ovalid && !m_axis_tready;
        if (r_state == S_MIX)
            n_ovalid = 1'b1;
        else if (r_state == S_IDLE && acc && !fire && !rd_ok)
            n_ovalid = 1'b1;
    end

    // frame memory: one port, read registered
    always_ff @(posedge i_clk) begin
        if (acc && in_op == OP_LOAD && 23'(in_addr) < 23'(FRAME_BYTES))
            r_mem[AW'(in_addr)] <= s_axis_tdata[28:21];
        else if (r_state == S_MIX && r_op == OP_BLEND)
            r_mem[r_addr] <= new_byte;
        if (r_state == S_READ)
            r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd2; r_turns <= 2'd0; r_w <= 11'd960; r_h <= 11'd540;
            r_fg <= 24'd0; r_bg <= 24'hFFFFFF; r_bgen <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:  r_mode  <= i_cfg_data[1:0];
                REG_TURNS: r_turns <= i_cfg_data[1:0];
                REG_W:     r_w     <= i_cfg_data[10:0];
                REG_H:     r_h     <= i_cfg_data[10:0];
                REG_FG:    r_fg    <= i_cfg_data;
                REG_BG:    r_bg    <= i_cfg_data;
                REG_BGEN:  r_bgen  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_alpha <= s_axis_tdata[68:61];
                        r_bitpos <= bpos;
                        if (fire) begin
                            r_op <= OP_BLEND;
                            r_addr <= bidx[AW-1:0];
                            r_state <= S_READ;
                        end else if (rd_ok) begin
                            r_op <= OP_READ;
                            r_addr <= AW'(in_addr);
                            r_state <= S_READ;
                        end else begin
                            r_odata <= {2'b00, in_oor, 13'd0};
                        end
                    end
                end
                S_READ: r_state <= S_MIX;
                S_MIX: begin
                    r_state <= S_IDLE;
                    if (r_op == OP_READ) r_odata <= {8'd0, r_rdata};
                    else r_odata <= {2'b00, 1'b0, color, 1'b1, 8'd0};
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_mix_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_MIX)) else $error("sequence broken");
    a_result_after_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX) |=> r_ovalid) else $error("result missing");
endmodule
